// ===== rtl/srfe_pkg.sv =====
// Shared types and constants of the smoothstep RGBW fade engine.
// Used by the interfaces, the controller, the datapath and the top level.
package srfe_pkg;

  localparam int unsigned LEVEL_W    = 10;
  localparam int unsigned STEP_W     = 10;
  localparam int unsigned FP_W       = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  // smoothstep fixed point: one and three times one
  localparam logic [FP_W-1:0] FP_ONE   = 16'hFFFF;
  localparam logic [17:0]     FP_THREE = 18'd196605;

  // item functions
  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_FADE   = 2'd1;
  localparam logic [1:0] FUNC_APPLY  = 2'd2;
  localparam logic [1:0] FUNC_IGNORE = 2'd3;

  // fade kinds
  localparam logic [1:0] KIND_ONOFF = 2'd0;
  localparam logic [1:0] KIND_LEVEL = 2'd1;
  localparam logic [1:0] KIND_COLOR = 2'd2;
  localparam logic [1:0] KIND_ALIAS = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FADE_EN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LUMA_EN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ON_STEPS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_STEPS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LVL_STEPS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COL_STEPS = 3'd5;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NOP,
    OP_TAKE,
    OP_SET_TGT,
    OP_SET_BOTH,
    OP_T_MUL,
    OP_T_DIV,
    OP_T2_MUL,
    OP_T2_DIV,
    OP_S_MUL,
    OP_S_DIV,
    OP_S_ONE,
    OP_CH_MUL,
    OP_CH_DIV,
    OP_NA_MUL,
    OP_NB_MUL,
    OP_DEN_MUL,
    OP_LU_MUL,
    OP_LU_DIV,
    OP_EMIT_CUR,
    OP_EMIT_TIN
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [STEP_W-1:0] step;
    logic [STEP_W-1:0] total;
    logic [1:0]        ch;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic shown_eq_tin;
    logic start_eq_tgt;
    logic mixed;
    logic ctot_zero;
    logic num_zero;
    logic cur_zero;
    logic tin_zero;
  } stat_t;

endpackage

// ===== rtl/srfe_if.sv =====
// Valid/ready channel interfaces of the fade engine: input, frame output, config.
// Depends on srfe_pkg for field widths.
interface srfe_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    func;
  logic [srfe_pkg::LEVEL_W-1:0]  target_red;
  logic [srfe_pkg::LEVEL_W-1:0]  target_green;
  logic [srfe_pkg::LEVEL_W-1:0]  target_blue;
  logic [srfe_pkg::LEVEL_W-1:0]  target_white;
  logic [1:0]                    fade_kind;
  logic                          restart;
  logic                          light_on;

  modport source (output valid, func, target_red, target_green, target_blue, target_white,
                  fade_kind, restart, light_on, input ready);
  modport sink (input valid, func, target_red, target_green, target_blue, target_white,
                fade_kind, restart, light_on, output ready);
endinterface

interface srfe_out_if;
  logic                          valid;
  logic                          ready;
  logic [srfe_pkg::LEVEL_W-1:0]  red;
  logic [srfe_pkg::LEVEL_W-1:0]  green;
  logic [srfe_pkg::LEVEL_W-1:0]  blue;
  logic [srfe_pkg::LEVEL_W-1:0]  white;
  logic                          fade_running;
  logic                          last_frame;

  modport source (output valid, red, green, blue, white, fade_running, last_frame,
                  input ready);
  modport sink (input valid, red, green, blue, white, fade_running, last_frame,
                output ready);
endinterface

interface srfe_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [srfe_pkg::CFG_IDX_W-1:0]  index;
  logic [srfe_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/srfe_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; used by srfe_dpath.
module srfe_div #(
  parameter int unsigned NUM_W = 38,
  parameter int unsigned DEN_W = 22
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W:0]   trial, diff;
  logic             ge;

  // trial subtract of the next partial remainder
  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  // control sequence
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== rtl/srfe_dpath.sv =====
// Datapath of the fade engine: color stores, shared multiplier and divider, frame register.
// Depends on srfe_pkg and srfe_div; driven by srfe_ctrl commands.
module srfe_dpath #(
  parameter int unsigned LEVEL_MAX = 1023
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  srfe_pkg::cmd_t                cmd_i,
  output srfe_pkg::stat_t               stat_o,
  input  logic [srfe_pkg::LEVEL_W-1:0]  target_red_i,
  input  logic [srfe_pkg::LEVEL_W-1:0]  target_green_i,
  input  logic [srfe_pkg::LEVEL_W-1:0]  target_blue_i,
  input  logic [srfe_pkg::LEVEL_W-1:0]  target_white_i,
  output logic [srfe_pkg::LEVEL_W-1:0]  red_o,
  output logic [srfe_pkg::LEVEL_W-1:0]  green_o,
  output logic [srfe_pkg::LEVEL_W-1:0]  blue_o,
  output logic [srfe_pkg::LEVEL_W-1:0]  white_o
);
  import srfe_pkg::*;

  localparam int unsigned CW = (LEVEL_MAX > 1023) ? $clog2(LEVEL_MAX + 1) : LEVEL_W;
  localparam int unsigned SW = CW + 2;
  localparam int unsigned NW = CW + 12;
  localparam int unsigned MA = NW;
  localparam int unsigned MB = FP_W;
  localparam int unsigned PW = MA + MB;
  localparam logic [16:0] LMAX = 17'(LEVEL_MAX);

  logic [CW-1:0]      tin_q [4];
  logic [CW-1:0]      shown_q [4];
  logic [CW-1:0]      start_q [4];
  logic [CW-1:0]      tgt_q [4];
  logic [CW-1:0]      cur_q [4];
  logic [LEVEL_W-1:0] frame_q [4];
  logic [LEVEL_W-1:0] tin_raw [4];
  logic [FP_W-1:0]    t_q, t2_q, s_q;
  logic [PW-1:0]      prod_q;
  logic [NW-1:0]      acc_q, num_q, den_q;
  op_e                dest_q;
  logic [1:0]         dch_q;

  logic [MA-1:0]      mul_a;
  logic [MB-1:0]      mul_b;
  logic [PW-1:0]      product;
  logic [STEP_W-1:0]  sm, nm;
  logic [SW-1:0]      sum_start, sum_tgt, ctot;
  logic [CW-1:0]      from_v, to_v, diff_v;
  logic               up_v;
  logic               div_start, div_done;
  logic [NW-1:0]      div_den;
  logic [PW-1:0]      quo;

  logic                 const_div, kdone_q;
  logic [PW-FP_W-1:0]   kq0;
  logic [PW-FP_W:0]     kr;
  logic [PW-2*FP_W:0]   kq1;
  logic [FP_W:0]        kr1;
  logic                 kcorr;
  logic [PW-1:0]        kquo_q, quo_w;

  assign tin_raw[0] = target_red_i;
  assign tin_raw[1] = target_green_i;
  assign tin_raw[2] = target_blue_i;
  assign tin_raw[3] = target_white_i;

  function automatic logic [CW-1:0] clamp_in(logic [LEVEL_W-1:0] v);
    clamp_in = ({7'b0, v} > LMAX) ? CW'(LMAX) : CW'(v);
  endfunction

  function automatic logic is_mixed(logic [CW-1:0] c0, logic [CW-1:0] c1,
                                    logic [CW-1:0] c2, logic [CW-1:0] c3);
    is_mixed = ((c0 != '0) || (c1 != '0) || (c2 != '0)) && (c3 != '0);
  endfunction

  // channel sums and clipped step
  assign sum_start = SW'(start_q[0]) + SW'(start_q[1]) + SW'(start_q[2]) + SW'(start_q[3]);
  assign sum_tgt   = SW'(tgt_q[0]) + SW'(tgt_q[1]) + SW'(tgt_q[2]) + SW'(tgt_q[3]);
  assign ctot      = SW'(cur_q[0]) + SW'(cur_q[1]) + SW'(cur_q[2]) + SW'(cur_q[3]);
  assign sm        = (cmd_i.step > cmd_i.total) ? cmd_i.total : cmd_i.step;
  assign nm        = cmd_i.total - sm;

  // per channel distance for the selected channel
  assign from_v = start_q[cmd_i.ch];
  assign to_v   = tgt_q[cmd_i.ch];
  assign up_v   = to_v >= from_v;
  assign diff_v = up_v ? (to_v - from_v) : (from_v - to_v);

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_T_MUL: begin
        mul_a = MA'(cmd_i.step);
        mul_b = FP_ONE;
      end
      OP_T2_MUL: begin
        mul_a = MA'(t_q);
        mul_b = t_q;
      end
      OP_S_MUL: begin
        mul_a = MA'(FP_THREE - {1'b0, t_q, 1'b0});
        mul_b = t2_q;
      end
      OP_CH_MUL: begin
        mul_a = MA'(diff_v);
        mul_b = s_q;
      end
      OP_NA_MUL: begin
        mul_a = MA'(sum_start);
        mul_b = MB'(nm);
      end
      OP_NB_MUL: begin
        mul_a = MA'(sum_tgt);
        mul_b = MB'(sm);
      end
      OP_DEN_MUL: begin
        mul_a = MA'(ctot);
        mul_b = MB'(cmd_i.total);
      end
      OP_LU_MUL: begin
        mul_a = num_q;
        mul_b = MB'(cur_q[cmd_i.ch]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign product = PW'(mul_a) * PW'(mul_b);

  // divider launch and divisor selection
  always_comb begin
    div_start = 1'b0;
    div_den   = NW'(FP_ONE);
    case (cmd_i.op)
      OP_T_DIV: begin
        div_start = 1'b1;
        div_den   = NW'(cmd_i.total);
      end
      OP_LU_DIV: begin
        div_start = 1'b1;
        div_den   = den_q;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  srfe_div #(
    .NUM_W (PW),
    .DEN_W (NW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod_q),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // divide by 65535: fold the high half into the low half twice, then one compare
  assign const_div = (cmd_i.op == OP_T2_DIV) || (cmd_i.op == OP_S_DIV) ||
                     (cmd_i.op == OP_CH_DIV);
  assign kq0   = prod_q[PW-1:FP_W];
  assign kr    = (PW-FP_W+1)'(prod_q[FP_W-1:0]) + (PW-FP_W+1)'(kq0);
  assign kq1   = kr[PW-FP_W:FP_W];
  assign kr1   = (FP_W+1)'(kr[FP_W-1:0]) + (FP_W+1)'(kq1);
  assign kcorr = kr1 >= {1'b0, FP_ONE};
  assign quo_w = kdone_q ? kquo_q : quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kdone_q <= 1'b0;
    end else begin
      kdone_q <= const_div;
    end
  end

  // fade state stores: shown, start and target colors
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        shown_q[i] <= '0;
        start_q[i] <= '0;
        tgt_q[i]   <= '0;
      end
    end else begin
      case (cmd_i.op)
        OP_SET_TGT: begin
          for (int i = 0; i < 4; i++) tgt_q[i] <= tin_q[i];
        end
        OP_SET_BOTH: begin
          for (int i = 0; i < 4; i++) begin
            tgt_q[i]   <= tin_q[i];
            start_q[i] <= shown_q[i];
          end
        end
        OP_EMIT_CUR: begin
          for (int i = 0; i < 4; i++) shown_q[i] <= cur_q[i];
        end
        OP_EMIT_TIN: begin
          for (int i = 0; i < 4; i++) shown_q[i] <= tin_q[i];
        end
        default: begin
        end
      endcase
    end
  end

  // working registers of the frame computation
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_TAKE: begin
        for (int i = 0; i < 4; i++) tin_q[i] <= clamp_in(tin_raw[i]);
      end
      OP_T_MUL, OP_T2_MUL, OP_S_MUL, OP_CH_MUL, OP_LU_MUL: prod_q <= product;
      OP_S_ONE:   s_q <= FP_ONE;
      OP_NA_MUL:  acc_q <= NW'(product);
      OP_NB_MUL:  num_q <= acc_q + NW'(product);
      OP_DEN_MUL: den_q <= NW'(product);
      OP_EMIT_CUR: begin
        for (int i = 0; i < 4; i++) frame_q[i] <= cur_q[i][LEVEL_W-1:0];
      end
      OP_EMIT_TIN: begin
        for (int i = 0; i < 4; i++) frame_q[i] <= tin_q[i][LEVEL_W-1:0];
      end
      default: begin
      end
    endcase
    if (const_div) begin
      kquo_q <= PW'(kq0) + PW'(kq1) + PW'(kcorr);
    end
    if (div_start || const_div) begin
      dest_q <= cmd_i.op;
      dch_q  <= cmd_i.ch;
    end
    // quotient write back
    if (div_done || kdone_q) begin
      case (dest_q)
        OP_T_DIV:  t_q  <= quo_w[FP_W-1:0];
        OP_T2_DIV: t2_q <= quo_w[FP_W-1:0];
        OP_S_DIV:  s_q  <= quo_w[FP_W-1:0];
        OP_CH_DIV: begin
          if (tgt_q[dch_q] >= start_q[dch_q]) cur_q[dch_q] <= start_q[dch_q] + quo_w[CW-1:0];
          else cur_q[dch_q] <= start_q[dch_q] - quo_w[CW-1:0];
        end
        OP_LU_DIV: begin
          cur_q[dch_q] <= (quo_w > PW'(LMAX)) ? CW'(LMAX) : quo_w[CW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // status toward the controller
  always_comb begin
    stat_o.div_done     = div_done || kdone_q;
    stat_o.shown_eq_tin = 1'b1;
    stat_o.start_eq_tgt = 1'b1;
    stat_o.cur_zero     = 1'b1;
    stat_o.tin_zero     = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (shown_q[i] != tin_q[i]) stat_o.shown_eq_tin = 1'b0;
      if (start_q[i] != tgt_q[i]) stat_o.start_eq_tgt = 1'b0;
      if (cur_q[i] != '0) stat_o.cur_zero = 1'b0;
      if (tin_q[i] != '0) stat_o.tin_zero = 1'b0;
    end
    stat_o.mixed     = is_mixed(start_q[0], start_q[1], start_q[2], start_q[3]) ||
                       is_mixed(tgt_q[0], tgt_q[1], tgt_q[2], tgt_q[3]);
    stat_o.ctot_zero = ctot == '0;
    stat_o.num_zero  = num_q == '0;
  end

  assign red_o   = frame_q[0];
  assign green_o = frame_q[1];
  assign blue_o  = frame_q[2];
  assign white_o = frame_q[3];

endmodule

// ===== rtl/srfe_ctrl.sv =====
// Controller of the fade engine: config registers, fade state and the frame sequencer.
// Depends on srfe_pkg; commands srfe_dpath.
module srfe_ctrl #(
  parameter int unsigned OFF_REPEAT = 2
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       func_i,
  input  logic [1:0]                       fade_kind_i,
  input  logic                             restart_i,
  input  logic                             light_on_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic                             fade_running_o,
  output logic                             last_frame_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [srfe_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [srfe_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output srfe_pkg::cmd_t                   cmd_o,
  input  srfe_pkg::stat_t                  stat_i
);
  import srfe_pkg::*;

  localparam int unsigned RW = $clog2(OFF_REPEAT + 1);

  typedef enum logic [18:0] {
    ST_IDLE   = 19'h00001,
    ST_DECODE = 19'h00002,
    ST_SETUP  = 19'h00004,
    ST_FRAME  = 19'h00008,
    ST_T_DIV  = 19'h00010,
    ST_T2_MUL = 19'h00020,
    ST_T2_DIV = 19'h00040,
    ST_S_MUL  = 19'h00080,
    ST_S_DIV  = 19'h00100,
    ST_CH_MUL = 19'h00200,
    ST_CH_DIV = 19'h00400,
    ST_LUMA   = 19'h00800,
    ST_NA     = 19'h01000,
    ST_NB     = 19'h02000,
    ST_DEN    = 19'h04000,
    ST_LCHK   = 19'h08000,
    ST_LU_MUL = 19'h10000,
    ST_LU_DIV = 19'h20000,
    ST_WAIT   = 19'h40000
  } state_e;

  // emit has no state of its own: a separate flag overrides the sequencer while a frame goes out
  state_e state_q, state_d, ret_q, ret_d;
  logic   emit_q, emit_d;

  logic              fade_en_q, luma_en_q;
  logic [STEP_W-1:0] on_steps_q, off_steps_q, lvl_steps_q, col_steps_q;
  logic [STEP_W-1:0] step_q, step_d, total_q, total_d, fs_q, fs_d, step_inc;
  logic              fading_q, fading_d;
  logic [1:0]        last_kind_q, last_kind_d;
  logic [1:0]        func_q, kind_q;
  logic              restart_q, on_q;
  logic [1:0]        ch_q, ch_d;
  logic              run_q, run_d, tin_src_q, tin_src_d;
  logic [RW-1:0]     rep_q, rep_d, rep_last;
  logic              out_valid_q, out_valid_d, out_run_q, out_run_d, out_last_q, out_last_d;
  logic              can_load, take;

  function automatic logic [STEP_W-1:0] steps_for(logic [1:0] kind, logic on,
                                                  logic [STEP_W-1:0] on_s,
                                                  logic [STEP_W-1:0] off_s,
                                                  logic [STEP_W-1:0] lvl_s,
                                                  logic [STEP_W-1:0] col_s);
    logic [STEP_W-1:0] v;
    if (kind == KIND_ONOFF) v = on ? on_s : off_s;
    else if (kind == KIND_COLOR) v = col_s;
    else v = lvl_s;
    steps_for = (v == '0) ? STEP_W'(1) : v;
  endfunction

  assign take        = in_valid_i && (state_q == ST_IDLE) && !emit_q;
  assign in_ready_o  = (state_q == ST_IDLE) && !emit_q;
  assign cfg_ready_o = 1'b1;
  assign can_load    = !out_valid_q || out_ready_i;
  assign step_inc    = step_q + 1'b1;
  assign rep_last    = (tin_src_q ? stat_i.tin_zero : stat_i.cur_zero) ?
                       RW'(OFF_REPEAT - 1) : '0;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_en_q   <= 1'b1;
      luma_en_q   <= 1'b1;
      on_steps_q  <= STEP_W'(50);
      off_steps_q <= STEP_W'(35);
      lvl_steps_q <= STEP_W'(32);
      col_steps_q <= STEP_W'(65);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FADE_EN:   fade_en_q   <= cfg_data_i[0];
        REG_LUMA_EN:   luma_en_q   <= cfg_data_i[0];
        REG_ON_STEPS:  on_steps_q  <= cfg_data_i;
        REG_OFF_STEPS: off_steps_q <= cfg_data_i;
        REG_LVL_STEPS: lvl_steps_q <= cfg_data_i;
        REG_COL_STEPS: col_steps_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // item control fields
  always_ff @(posedge clk_i) begin
    if (take) begin
      func_q    <= func_i;
      kind_q    <= (fade_kind_i == KIND_ALIAS) ? KIND_LEVEL : fade_kind_i;
      restart_q <= restart_i;
      on_q      <= light_on_i;
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    emit_d      = emit_q;
    step_d      = step_q;
    total_d     = total_q;
    fs_d        = fs_q;
    fading_d    = fading_q;
    last_kind_d = last_kind_q;
    ch_d        = ch_q;
    run_d       = run_q;
    tin_src_d   = tin_src_q;
    rep_d       = rep_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_run_d   = out_run_q;
    out_last_d  = out_last_q;
    cmd_o.op    = OP_NOP;
    cmd_o.step  = fs_q;
    cmd_o.total = total_q;
    cmd_o.ch    = ch_q;

    if (emit_q) begin
      // frame output, repeated for an all-zero frame
      if (can_load) begin
        cmd_o.op    = tin_src_q ? OP_EMIT_TIN : OP_EMIT_CUR;
        out_valid_d = 1'b1;
        out_run_d   = run_q;
        out_last_d  = rep_q == rep_last;
        if (rep_q == rep_last) begin
          emit_d = 1'b0;
          rep_d  = '0;
        end else begin
          rep_d = rep_q + 1'b1;
        end
      end
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (take) begin
            cmd_o.op = OP_TAKE;
            state_d  = ST_DECODE;
          end
        end
        ST_DECODE: begin
          tin_src_d = 1'b0;
          state_d   = ST_IDLE;
          if (func_q == FUNC_TICK) begin
            if (fading_q) begin
              step_d  = step_inc;
              state_d = ST_FRAME;
              if (step_inc >= total_q) begin
                fading_d = 1'b0;
                fs_d     = total_q;
                run_d    = 1'b0;
              end else begin
                fs_d  = step_inc;
                run_d = 1'b1;
              end
            end
          end else if (func_q == FUNC_IGNORE) begin
            state_d = ST_IDLE;
          end else if (func_q == FUNC_APPLY || !fade_en_q) begin
            fading_d  = 1'b0;
            tin_src_d = 1'b1;
            run_d     = 1'b0;
            emit_d    = 1'b1;
          end else if (kind_q == KIND_COLOR && fading_q && last_kind_q == KIND_COLOR &&
                       !restart_q) begin
            // color retarget keeps the running step
            cmd_o.op = OP_SET_TGT;
            if (stat_i.shown_eq_tin) begin
              fading_d = 1'b0;
            end else if (total_q != '0) begin
              fs_d    = step_q;
              run_d   = 1'b1;
              state_d = ST_FRAME;
            end
          end else begin
            cmd_o.op    = (!fading_q || restart_q || last_kind_q != kind_q) ?
                          OP_SET_BOTH : OP_SET_TGT;
            last_kind_d = kind_q;
            state_d     = ST_SETUP;
          end
        end
        ST_SETUP: begin
          state_d = ST_FRAME;
          if (stat_i.start_eq_tgt) begin
            fading_d = 1'b0;
            fs_d     = total_q;
            run_d    = 1'b0;
          end else begin
            step_d   = '0;
            total_d  = steps_for(kind_q, on_q, on_steps_q, off_steps_q, lvl_steps_q,
                                 col_steps_q);
            fading_d = 1'b1;
            fs_d     = '0;
            run_d    = 1'b1;
          end
        end
        ST_FRAME: begin
          ch_d = '0;
          if (total_q == '0 || fs_q >= total_q) begin
            cmd_o.op = OP_S_ONE;
            state_d  = ST_CH_MUL;
          end else begin
            cmd_o.op = OP_T_MUL;
            state_d  = ST_T_DIV;
          end
        end
        ST_T_DIV: begin
          cmd_o.op = OP_T_DIV;
          ret_d    = ST_T2_MUL;
          state_d  = ST_WAIT;
        end
        ST_T2_MUL: begin
          cmd_o.op = OP_T2_MUL;
          state_d  = ST_T2_DIV;
        end
        ST_T2_DIV: begin
          cmd_o.op = OP_T2_DIV;
          ret_d    = ST_S_MUL;
          state_d  = ST_WAIT;
        end
        ST_S_MUL: begin
          cmd_o.op = OP_S_MUL;
          state_d  = ST_S_DIV;
        end
        ST_S_DIV: begin
          cmd_o.op = OP_S_DIV;
          ret_d    = ST_CH_MUL;
          state_d  = ST_WAIT;
        end
        ST_CH_MUL: begin
          cmd_o.op = OP_CH_MUL;
          state_d  = ST_CH_DIV;
        end
        ST_CH_DIV: begin
          cmd_o.op = OP_CH_DIV;
          ch_d     = ch_q + 1'b1;
          ret_d    = (ch_q == 2'd3) ? ST_LUMA : ST_CH_MUL;
          state_d  = ST_WAIT;
        end
        ST_LUMA: begin
          if (luma_en_q && total_q != '0 && stat_i.mixed) begin
            state_d = ST_NA;
          end else begin
            state_d = ST_IDLE;
            emit_d  = 1'b1;
          end
        end
        ST_NA: begin
          cmd_o.op = OP_NA_MUL;
          state_d  = ST_NB;
        end
        ST_NB: begin
          cmd_o.op = OP_NB_MUL;
          state_d  = ST_DEN;
        end
        ST_DEN: begin
          cmd_o.op = OP_DEN_MUL;
          state_d  = ST_LCHK;
        end
        ST_LCHK: begin
          if (stat_i.ctot_zero || stat_i.num_zero) begin
            state_d = ST_IDLE;
            emit_d  = 1'b1;
          end else begin
            state_d = ST_LU_MUL;
          end
        end
        ST_LU_MUL: begin
          cmd_o.op = OP_LU_MUL;
          state_d  = ST_LU_DIV;
        end
        ST_LU_DIV: begin
          cmd_o.op = OP_LU_DIV;
          ch_d     = ch_q + 1'b1;
          ret_d    = (ch_q == 2'd3) ? ST_IDLE : ST_LU_MUL;
          state_d  = ST_WAIT;
        end
        ST_WAIT: begin
          if (stat_i.div_done) begin
            state_d = ret_q;
            if (ret_q == ST_IDLE) emit_d = 1'b1;
          end
        end
        default: begin
          state_d = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= ST_IDLE;
      emit_q      <= 1'b0;
      step_q      <= '0;
      total_q     <= '0;
      fs_q        <= '0;
      fading_q    <= 1'b0;
      last_kind_q <= KIND_ONOFF;
      ch_q        <= '0;
      run_q       <= 1'b0;
      tin_src_q   <= 1'b0;
      rep_q       <= '0;
      out_valid_q <= 1'b0;
      out_run_q   <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      emit_q      <= emit_d;
      step_q      <= step_d;
      total_q     <= total_d;
      fs_q        <= fs_d;
      fading_q    <= fading_d;
      last_kind_q <= last_kind_d;
      ch_q        <= ch_d;
      run_q       <= run_d;
      tin_src_q   <= tin_src_d;
      rep_q       <= rep_d;
      out_valid_q <= out_valid_d;
      out_run_q   <= out_run_d;
      out_last_q  <= out_last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign fade_running_o = out_run_q;
  assign last_frame_o   = out_last_q;

endmodule

// ===== rtl/smoothstep_rgbw_fade_engine_unit.sv =====
// Top level of the smoothstep RGBW fade engine: controller plus datapath.
// Depends on srfe_pkg, srfe_if, srfe_ctrl and srfe_dpath.
//
// Fades four LED channels toward a target along a 16-bit smoothstep curve, one
// frame per tick word while a fade runs; a fade word starts or retargets a
// fade, an apply word shows its color at once. Words are taken one at a time.
// An apply word goes from decode straight to the output and an ignored word
// from decode back to idle. A fade frame runs one division on a shared
// restoring divider (one quotient bit a cycle, 38 bits at LEVEL_MAX 1023) and
// divides by 65535 with a short fold and compare; brightness compensation adds
// four more divider runs. An all-zero frame goes out OFF_REPEAT times;
// a finished frame waits in the output register while the next word is taken.
// Config writes are always ready and must come while idle.
module smoothstep_rgbw_fade_engine_unit #(
  parameter int unsigned LEVEL_MAX  = 1023,
  parameter int unsigned OFF_REPEAT = 2
) (
  input logic        clk_i,
  input logic        rst_ni,
  srfe_in_if.sink    in_i,
  srfe_out_if.source out_o,
  srfe_cfg_if.sink   cfg_i
);
  import srfe_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  srfe_ctrl #(
    .OFF_REPEAT (OFF_REPEAT)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_i.valid),
    .in_ready_o     (in_i.ready),
    .func_i         (in_i.func),
    .fade_kind_i    (in_i.fade_kind),
    .restart_i      (in_i.restart),
    .light_on_i     (in_i.light_on),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .fade_running_o (out_o.fade_running),
    .last_frame_o   (out_o.last_frame),
    .cfg_valid_i    (cfg_i.valid),
    .cfg_ready_o    (cfg_i.ready),
    .cfg_index_i    (cfg_i.index),
    .cfg_data_i     (cfg_i.data),
    .cmd_o          (cmd),
    .stat_i         (stat)
  );

  srfe_dpath #(
    .LEVEL_MAX (LEVEL_MAX)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .target_red_i   (in_i.target_red),
    .target_green_i (in_i.target_green),
    .target_blue_i  (in_i.target_blue),
    .target_white_i (in_i.target_white),
    .red_o          (out_o.red),
    .green_o        (out_o.green),
    .blue_o         (out_o.blue),
    .white_o        (out_o.white)
  );

endmodule

// ===== dv/srfe_frame_checker.sv =====
// Frame checker of the smoothstep RGBW fade engine: watches the input, config and
// frame channels, predicts every frame and compares. Depends on srfe_pkg, srfe_if.
`timescale 1ns / 100ps
module srfe_frame_checker
  import srfe_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  srfe_in_if                 in_mon,
  srfe_out_if                out_mon,
  srfe_cfg_if                cfg_mon,
  output int                 fail_count_o,
  output int                 pending_o,
  output logic [LEVEL_W-1:0] shown_o [4]
);

  localparam int unsigned LVL_MAX  = 1023;
  localparam int unsigned ZERO_REP = 2;
  localparam longint unsigned ONE  = 65535;

  typedef struct {
    logic [LEVEL_W-1:0] ch [4];
    logic               running;
    logic               last;
  } frame_t;

  frame_t expected_frames[$];

  // register copies
  logic              fade_en;
  logic              luma_en;
  logic [STEP_W-1:0] on_steps, off_steps, lvl_steps, col_steps;

  // fade state
  logic [LEVEL_W-1:0] shown [4];
  logic [LEVEL_W-1:0] start_c [4];
  logic [LEVEL_W-1:0] tgt_c [4];
  logic [STEP_W-1:0]  step_cnt, total;
  logic               fading;
  logic [1:0]         last_kind;

  assign pending_o = expected_frames.size();
  assign shown_o   = shown;

  function automatic longint unsigned curve(longint unsigned stp, longint unsigned tot);
    longint unsigned t, t2;
    if (tot == 0 || stp >= tot) return ONE;
    t  = stp * ONE / tot;
    t2 = t * t / ONE;
    return t2 * (3 * ONE - 2 * t) / ONE;
  endfunction

  function automatic longint unsigned blend(longint unsigned a, longint unsigned b,
                                            longint unsigned stp, longint unsigned tot);
    longint unsigned s, r;
    if (tot == 0 || stp >= tot) r = b;
    else begin
      s = curve(stp, tot);
      if (b >= a) r = a + (b - a) * s / ONE;
      else r = a - (a - b) * s / ONE;
    end
    return (r > LVL_MAX) ? LVL_MAX : r;
  endfunction

  function automatic bit is_mixed(logic [LEVEL_W-1:0] c [4]);
    return (c[0] != 0 || c[1] != 0 || c[2] != 0) && c[3] != 0;
  endfunction

  function automatic longint unsigned sum_of(logic [LEVEL_W-1:0] c [4]);
    return longint'(c[0]) + c[1] + c[2] + c[3];
  endfunction

  // queue a frame, repeated when all zero, and make it the shown color
  function automatic void show_frame(logic [LEVEL_W-1:0] c [4], logic run);
    frame_t f;
    int     reps;
    reps = (c[0] | c[1] | c[2] | c[3]) == 0 ? ZERO_REP : 1;
    for (int k = 0; k < reps; k++) begin
      f.ch      = c;
      f.running = run;
      f.last    = (k == reps - 1);
      expected_frames.push_back(f);
    end
    shown = c;
  endfunction

  function automatic void fade_frame(longint unsigned stp);
    logic [LEVEL_W-1:0] cur [4];
    longint unsigned    n, s, ctot, num, den, v;
    for (int i = 0; i < 4; i++) cur[i] = LEVEL_W'(blend(start_c[i], tgt_c[i], stp, total));
    if (luma_en && total > 0 && (is_mixed(start_c) || is_mixed(tgt_c))) begin
      n    = total;
      s    = (stp > n) ? n : stp;
      ctot = sum_of(cur);
      num  = sum_of(start_c) * (n - s) + sum_of(tgt_c) * s;
      if (ctot != 0 && num != 0) begin
        den = n * ctot;
        for (int i = 0; i < 4; i++) begin
          v      = cur[i] * num / den;
          cur[i] = LEVEL_W'((v > LVL_MAX) ? LVL_MAX : v);
        end
      end
    end
    show_frame(cur, fading);
  endfunction

  function automatic logic [STEP_W-1:0] fade_length(logic [1:0] kind, logic on);
    logic [STEP_W-1:0] v;
    if (kind == KIND_ONOFF) v = on ? on_steps : off_steps;
    else if (kind == KIND_COLOR) v = col_steps;
    else v = lvl_steps;
    return (v == 0) ? STEP_W'(1) : v;
  endfunction

  function automatic void fade_predict(logic [1:0] func, logic [LEVEL_W-1:0] tin [4],
                                       logic [1:0] kind_in, logic restart, logic on);
    logic [1:0] kind;
    kind = (kind_in == KIND_ALIAS) ? KIND_LEVEL : kind_in;
    if (func == FUNC_TICK) begin
      if (!fading) return;
      step_cnt = step_cnt + 1'b1;
      if (step_cnt >= total) begin
        fading = 0;
        fade_frame(total);
      end else fade_frame(step_cnt);
      return;
    end
    if (func == FUNC_IGNORE) return;
    if (func == FUNC_APPLY || !fade_en) begin
      fading = 0;
      show_frame(tin, 0);
      return;
    end
    tgt_c = tin;
    // color retarget keeps the running step
    if (kind == KIND_COLOR && fading && last_kind == KIND_COLOR && !restart) begin
      if (shown == tgt_c) fading = 0;
      else if (total > 0) fade_frame(step_cnt);
      return;
    end
    if (!fading || restart || last_kind != kind) start_c = shown;
    last_kind = kind;
    if (start_c == tgt_c) begin
      fading = 0;
      fade_frame(total);
      return;
    end
    step_cnt = 0;
    total    = fade_length(kind, on);
    fading   = 1;
    fade_frame(0);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [LEVEL_W-1:0] tin [4];
    frame_t             e;
    if (!rst_ni) begin
      fade_en      = 1;
      luma_en      = 1;
      on_steps     = 50;
      off_steps    = 35;
      lvl_steps    = 32;
      col_steps    = 65;
      for (int i = 0; i < 4; i++) begin
        shown[i] = 0; start_c[i] = 0; tgt_c[i] = 0;
      end
      step_cnt     = 0;
      total        = 0;
      fading       = 0;
      last_kind    = KIND_ONOFF;
      fail_count_o = 0;
      expected_frames.delete();
    end else begin
      // compare an accepted frame word
      if (out_mon.valid && out_mon.ready) begin
        if (expected_frames.size() == 0) begin
          $error("frame word with no expectation waiting");
          fail_count_o++;
        end else begin
          e = expected_frames.pop_front();
          if (out_mon.red !== e.ch[0]) begin
            $error("red: expected %0d actual %0d", e.ch[0], out_mon.red); fail_count_o++;
          end
          if (out_mon.green !== e.ch[1]) begin
            $error("green: expected %0d actual %0d", e.ch[1], out_mon.green); fail_count_o++;
          end
          if (out_mon.blue !== e.ch[2]) begin
            $error("blue: expected %0d actual %0d", e.ch[2], out_mon.blue); fail_count_o++;
          end
          if (out_mon.white !== e.ch[3]) begin
            $error("white: expected %0d actual %0d", e.ch[3], out_mon.white); fail_count_o++;
          end
          if (out_mon.fade_running !== e.running) begin
            $error("fade_running: expected %0d actual %0d", e.running, out_mon.fade_running);
            fail_count_o++;
          end
          if (out_mon.last_frame !== e.last) begin
            $error("last_frame: expected %0d actual %0d", e.last, out_mon.last_frame);
            fail_count_o++;
          end
        end
      end
      // register write
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_FADE_EN:   fade_en   = cfg_mon.data[0];
          REG_LUMA_EN:   luma_en   = cfg_mon.data[0];
          REG_ON_STEPS:  on_steps  = cfg_mon.data;
          REG_OFF_STEPS: off_steps = cfg_mon.data;
          REG_LVL_STEPS: lvl_steps = cfg_mon.data;
          REG_COL_STEPS: col_steps = cfg_mon.data;
          default: ;
        endcase
      end
      // input word
      if (in_mon.valid && in_mon.ready) begin
        tin[0] = in_mon.target_red;
        tin[1] = in_mon.target_green;
        tin[2] = in_mon.target_blue;
        tin[3] = in_mon.target_white;
        fade_predict(in_mon.func, tin, in_mon.fade_kind, in_mon.restart, in_mon.light_on);
      end
    end
  end

endmodule

// ===== dv/smoothstep_rgbw_fade_engine_unit_tb.sv =====
// Testbench top of the smoothstep RGBW fade engine: clock, reset, stimulus and verdict.
// Depends on srfe_pkg, srfe_if, the block and srfe_frame_checker.
`timescale 1ns / 100ps
module smoothstep_rgbw_fade_engine_unit_tb;
  import srfe_pkg::*;

  localparam int     DRAIN_CYCLES = 1200;
  localparam longint CYCLE_LIMIT  = 3000000;

  logic clk_i = 0;
  logic rst_ni = 0;
  int   fail_count;
  int   pending;
  int   words_sent = 0;
  longint cycles = 0;
  logic [LEVEL_W-1:0] shown [4];

  srfe_in_if  in_ch ();
  srfe_out_if out_ch ();
  srfe_cfg_if cfg_ch ();

  smoothstep_rgbw_fade_engine_unit i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source),
    .cfg_i (cfg_ch.sink)
  );

  srfe_frame_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_mon     (cfg_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .shown_o     (shown)
  );

  always #1 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // frame receiver, with one long hold-off so the block backs up
  initial begin
    bit held;
    held = 0;
    out_ch.ready = 0;
    @(posedge rst_ni);
    forever begin
      if (!held && words_sent >= 150) begin
        held = 1;
        out_ch.ready <= 0;
        repeat (4000) @(posedge clk_i);
      end else if ($urandom_range(2) == 0) begin
        out_ch.ready <= 0;
        repeat (gap_len() + 1) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end
    end
  end

  task automatic send_word(logic [1:0] func, logic [LEVEL_W-1:0] r, logic [LEVEL_W-1:0] g,
                           logic [LEVEL_W-1:0] b, logic [LEVEL_W-1:0] w, logic [1:0] kind,
                           logic restart, logic on);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid        <= 1;
    in_ch.func         <= func;
    in_ch.target_red   <= r;
    in_ch.target_green <= g;
    in_ch.target_blue  <= b;
    in_ch.target_white <= w;
    in_ch.fade_kind    <= kind;
    in_ch.restart      <= restart;
    in_ch.light_on     <= on;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic idle_in();
    in_ch.valid <= 0;
    @(posedge clk_i);
  endtask

  // wait for all frames with the input idle, then for a further drain period
  task automatic drain();
    idle_in();
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 0;
    @(posedge clk_i);
  endtask

  task automatic set_regs(logic fe, logic le, logic [9:0] on_s, logic [9:0] off_s,
                          logic [9:0] lvl_s, logic [9:0] col_s);
    write_reg(REG_FADE_EN, CFG_DATA_W'(fe));
    write_reg(REG_LUMA_EN, CFG_DATA_W'(le));
    write_reg(REG_ON_STEPS, on_s);
    write_reg(REG_OFF_STEPS, off_s);
    write_reg(REG_LVL_STEPS, lvl_s);
    write_reg(REG_COL_STEPS, col_s);
  endtask

  task automatic random_word();
    logic [LEVEL_W-1:0] c [4];
    logic [1:0]         func;
    int                 r, mode;
    r = $urandom_range(99);
    func = (r < 55) ? FUNC_TICK : (r < 82) ? FUNC_FADE : (r < 94) ? FUNC_APPLY : FUNC_IGNORE;
    mode = $urandom_range(9);
    for (int i = 0; i < 4; i++) begin
      case (mode)
        0:       c[i] = 0;
        1:       c[i] = 10'd1023;
        2:       c[i] = (i == 3) ? 10'd0 : 10'($urandom_range(0, 1023));
        3:       c[i] = shown[i];
        default: c[i] = 10'($urandom_range(0, 1023));
      endcase
    end
    send_word(func, c[0], c[1], c[2], c[3], 2'($urandom_range(3)),
              $urandom_range(4) == 0, 1'($urandom_range(1)));
  endtask

  task automatic random_phase(int count);
    for (int k = 0; k < count; k++) random_word();
    drain();
  endtask

  initial begin
    in_ch.valid = 0; in_ch.func = FUNC_TICK; in_ch.fade_kind = KIND_ONOFF;
    in_ch.target_red = 0; in_ch.target_green = 0; in_ch.target_blue = 0;
    in_ch.target_white = 0; in_ch.restart = 0; in_ch.light_on = 0;
    cfg_ch.valid = 0; cfg_ch.index = REG_FADE_EN; cfg_ch.data = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed words at reset settings
    send_word(FUNC_TICK, 0, 0, 0, 0, KIND_ONOFF, 0, 1);          // tick while idle
    send_word(FUNC_APPLY, 0, 0, 0, 0, KIND_ONOFF, 0, 0);         // zero frame repeats
    send_word(FUNC_APPLY, 1023, 1023, 1023, 1023, KIND_LEVEL, 1, 1);
    send_word(FUNC_FADE, 1023, 0, 0, 512, KIND_COLOR, 0, 1);
    send_word(FUNC_TICK, 0, 0, 0, 0, KIND_ONOFF, 0, 0);
    send_word(FUNC_TICK, 0, 0, 0, 0, KIND_ONOFF, 0, 0);
    send_word(FUNC_FADE, 0, 1023, 0, 0, KIND_COLOR, 0, 1);       // retarget keeps step
    send_word(FUNC_TICK, 0, 0, 0, 0, KIND_ONOFF, 0, 0);
    send_word(FUNC_FADE, 5, 600, 0, 1023, KIND_COLOR, 1, 1);     // forced fresh fade
    send_word(FUNC_IGNORE, 1023, 1023, 1023, 1023, KIND_ALIAS, 1, 1);
    send_word(FUNC_FADE, 200, 300, 400, 0, KIND_ALIAS, 0, 0);    // alias kind as level
    send_word(FUNC_TICK, 0, 0, 0, 0, KIND_ONOFF, 0, 0);
    send_word(FUNC_FADE, 0, 0, 0, 0, KIND_ONOFF, 0, 0);          // fade off
    for (int k = 0; k < 6; k++) send_word(FUNC_TICK, 0, 0, 0, 0, KIND_ONOFF, 0, 0);
    send_word(FUNC_FADE, 0, 0, 0, 0, KIND_ONOFF, 0, 1);          // same zero target, fade starts over
    drain();

    // short fades so the random part finishes them often
    set_regs(1, 1, 3, 2, 4, 5);
    random_phase(110);
    set_regs(1, 0, 1, 6, 2, 3);
    random_phase(90);
    set_regs(0, 1, 7, 7, 7, 7);                                  // fading disabled
    random_phase(60);
    set_regs(1, 1, 0, 1023, 0, 1023);                            // zero and longest lengths
    random_phase(80);
    set_regs(1, 1, 1, 1, 1, 1);
    random_phase(80);
    set_regs(1, 0, 4, 3, 2, 8);
    random_phase(90);

    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
